// ===== rtl/blpg_pkg.sv =====
// Package for the Bresenham line pixel generator.
// Holds field widths, parameter defaults, the controller-to-datapath command type and the status type.
// No dependencies.
package blpg_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COORD_W        = 6;
    localparam int COLOR_W        = 8;

    typedef struct packed {
        logic load;
        logic step;
    } blpg_cmd_t;

    typedef struct packed {
        logic last;
    } blpg_status_t;

endpackage

// ===== rtl/blpg_dp.sv =====
// Datapath of the line pixel generator: setup of spans, directions and error term,
// and the per-pixel step of coordinates, error term and remaining count.
// Depends on blpg_pkg.
module blpg_dp #(
    parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  blpg_pkg::blpg_cmd_t          cmd,
    output blpg_pkg::blpg_status_t       status,
    input  logic [blpg_pkg::COORD_W-1:0] s_start_x,
    input  logic [blpg_pkg::COORD_W-1:0] s_start_y,
    input  logic [blpg_pkg::COORD_W-1:0] s_end_x,
    input  logic [blpg_pkg::COORD_W-1:0] s_end_y,
    input  logic [blpg_pkg::COLOR_W-1:0] s_red,
    input  logic [blpg_pkg::COLOR_W-1:0] s_green,
    input  logic [blpg_pkg::COLOR_W-1:0] s_blue,
    output logic [blpg_pkg::COORD_W-1:0] m_pixel_x,
    output logic [blpg_pkg::COORD_W-1:0] m_pixel_y,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_red,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_green,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_blue,
    output logic                         m_final_pixel
);

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + 2;

    logic [CB-1:0] x0, y0, x1, y1;
    logic [CB-1:0] adx, ady, dmaj, dmin;
    logic          sx_neg, sy_neg, ymaj;
    logic signed [ERR_W-1:0] two_dmin, two_diff, pk_init;

    logic [CB-1:0]           x_reg, x_next, y_reg, y_next;
    logic [CB-1:0]           steps_reg, steps_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ERR_W-1:0] inc_min_reg, inc_min_next;
    logic signed [ERR_W-1:0] inc_both_reg, inc_both_next;
    logic                    sx_neg_reg, sy_neg_reg, ymaj_reg;
    logic [blpg_pkg::COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic                    minor_step;

    always_comb begin
        x0     = s_start_x[CB-1:0];
        y0     = s_start_y[CB-1:0];
        x1     = s_end_x[CB-1:0];
        y1     = s_end_y[CB-1:0];
        sx_neg = x1 < x0;
        sy_neg = y1 < y0;
        adx    = sx_neg ? (x0 - x1) : (x1 - x0);
        ady    = sy_neg ? (y0 - y1) : (y1 - y0);
        ymaj   = !(adx > ady);
        dmaj   = ymaj ? ady : adx;
        dmin   = ymaj ? adx : ady;
        two_dmin = $signed({1'b0, dmin, 1'b0});
        two_diff = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
        pk_init  = $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj});
    end

    assign minor_step = !err_reg[ERR_W-1];

    always_comb begin
        x_next        = x_reg;
        y_next        = y_reg;
        err_next      = err_reg;
        steps_next    = steps_reg;
        inc_min_next  = inc_min_reg;
        inc_both_next = inc_both_reg;
        if (cmd.load) begin
            x_next        = x0;
            y_next        = y0;
            err_next      = pk_init;
            steps_next    = dmaj;
            inc_min_next  = two_dmin;
            inc_both_next = two_diff;
        end else if (cmd.step) begin
            steps_next = steps_reg - CB'(1);
            if (ymaj_reg || minor_step) begin
                y_next = sy_neg_reg ? (y_reg - CB'(1)) : (y_reg + CB'(1));
            end
            if (!ymaj_reg || minor_step) begin
                x_next = sx_neg_reg ? (x_reg - CB'(1)) : (x_reg + CB'(1));
            end
            err_next = minor_step ? (err_reg + inc_both_reg) : (err_reg + inc_min_reg);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        steps_reg    <= steps_next;
        inc_min_reg  <= inc_min_next;
        inc_both_reg <= inc_both_next;
        if (cmd.load) begin
            sx_neg_reg <= sx_neg;
            sy_neg_reg <= sy_neg;
            ymaj_reg   <= ymaj;
            red_reg    <= s_red;
            green_reg  <= s_green;
            blue_reg   <= s_blue;
        end
    end

    assign status.last    = steps_reg == '0;
    assign m_pixel_x      = blpg_pkg::COORD_W'(x_reg);
    assign m_pixel_y      = blpg_pkg::COORD_W'(y_reg);
    assign m_pixel_red    = red_reg;
    assign m_pixel_green  = green_reg;
    assign m_pixel_blue   = blue_reg;
    assign m_final_pixel  = status.last;

endmodule

// ===== rtl/blpg_ctrl.sv =====
// Controller of the line pixel generator: request intake and pixel transfer sequencing.
// Depends on blpg_pkg.
module blpg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  blpg_pkg::blpg_status_t status,
    output blpg_pkg::blpg_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;
    logic done;

    assign done     = (state_reg == ST_EMIT) && m_ready && status.last;
    assign s_ready  = (state_reg == ST_IDLE) || done;
    assign m_valid  = state_reg == ST_EMIT;
    assign cmd.load = s_valid && s_ready;
    assign cmd.step = (state_reg == ST_EMIT) && m_ready && !status.last;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (done && !cmd.load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_load_and_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.step))
        else $error("load and step in the same cycle");

    a_load_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_EMIT)
        else $error("request accepted without entering emit");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done && !s_valid |=> state_reg == ST_IDLE)
        else $error("final pixel transfer did not end the line");

    a_step_keeps_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> m_valid)
        else $error("pixel stream broke off before the final pixel");

endmodule

// ===== rtl/bresenham_line_pixel_generator_unit.sv =====
// Bresenham line pixel generator, top level: controller plus datapath.
// The first pixel is offered in the cycle after the request transfer.
// Throughput: one pixel per cycle while m_ready is high, max(|dx|,|dy|)+1 pixels per line (1 to 64);
// the next request is taken with the final pixel.
// Reset: aresetn synchronous, active low, returns the controller to idle.
// Depends on blpg_pkg, blpg_ctrl, blpg_dp.
module bresenham_line_pixel_generator_unit #(
    parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [blpg_pkg::COORD_W-1:0] s_start_x,
    input  logic [blpg_pkg::COORD_W-1:0] s_start_y,
    input  logic [blpg_pkg::COORD_W-1:0] s_end_x,
    input  logic [blpg_pkg::COORD_W-1:0] s_end_y,
    input  logic [blpg_pkg::COLOR_W-1:0] s_red,
    input  logic [blpg_pkg::COLOR_W-1:0] s_green,
    input  logic [blpg_pkg::COLOR_W-1:0] s_blue,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [blpg_pkg::COORD_W-1:0] m_pixel_x,
    output logic [blpg_pkg::COORD_W-1:0] m_pixel_y,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_red,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_green,
    output logic [blpg_pkg::COLOR_W-1:0] m_pixel_blue,
    output logic                         m_final_pixel
);

    blpg_pkg::blpg_cmd_t    cmd;
    blpg_pkg::blpg_status_t status;

    blpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    blpg_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_red   (m_pixel_red),
        .m_pixel_green (m_pixel_green),
        .m_pixel_blue  (m_pixel_blue),
        .m_final_pixel (m_final_pixel)
    );

endmodule
